// ===== rtl/sfp_pkg.sv =====
// Shared types and constants for the sensor UART frame parser.
// No dependencies; sfp_frame_dec and the parser top level import this package.
package sfp_pkg;

  // Frame geometry: header, type, payload and one trailing checksum byte
  localparam int FRAME_LEN = 9;
  // Bytes kept in flops; the checksum byte is compared on arrival, not stored
  localparam int STORE_LEN = FRAME_LEN - 1;
  localparam int IDX_W     = $clog2(STORE_LEN);
  localparam int CNT_W     = 4;
  localparam int IDLE_W    = 17;
  localparam int TMO_W     = 16;
  localparam int PPB_W     = 16;

  localparam logic [CNT_W-1:0]  FRAME_CNT   = CNT_W'(FRAME_LEN);
  localparam logic [CNT_W-1:0]  CHK_CNT     = CNT_W'(FRAME_LEN - 1);
  localparam logic [IDLE_W-1:0] IDLE_MAX    = {IDLE_W{1'b1}};
  localparam logic [TMO_W-1:0]  TMO_RESET   = 16'd100;

  // Protocol codes
  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] TYPE_UPLOAD = 8'h17;
  localparam logic [7:0] TYPE_QUERY  = 8'h86;

  // Item kinds on the input channel
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Stored frame bytes 0 .. STORE_LEN-1
  typedef logic [STORE_LEN-1:0][7:0] store_t;

  // Decoder verdict for a frame completed by the checksum byte
  typedef struct packed {
    logic             sum_ok;
    logic             hit;
    logic [PPB_W-1:0] tvoc_ppb;
    logic             from_query;
  } dec_t;

endpackage

// ===== rtl/sfp_in_if.sv =====
// Input channel of the frame parser: one received byte or one tick per transaction.
// Standalone; the widths match sfp_pkg.
interface sfp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink   (input valid, func, rx_byte, output ready);
endinterface

// ===== rtl/sfp_out_if.sv =====
// Result channel of the frame parser: one ppb reading per transaction.
// Standalone; the widths match sfp_pkg.
interface sfp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tvoc_ppb;
  logic        from_query;

  modport source (output valid, tvoc_ppb, from_query, input ready);
  modport sink   (input valid, tvoc_ppb, from_query, output ready);
endinterface

// ===== rtl/sfp_frame_dec.sv =====
// Checksum test and header/type decode of a frame whose last byte is arriving.
// Depends on sfp_pkg.
module sfp_frame_dec (
  input  sfp_pkg::store_t frame,
  input  logic [7:0]      chk_byte,
  output sfp_pkg::dec_t   dec
);
  import sfp_pkg::*;

  logic [7:0] acc;
  logic [7:0] chk_exp;

  // Sum bytes 1..7 modulo 256 and negate
  always_comb begin
    acc = 8'd0;
    for (int i = 1; i < STORE_LEN; i++) begin
      acc = acc + frame[i];
    end
    chk_exp = ~acc + 8'd1;
  end

  // Pick the reading by frame type
  always_comb begin
    dec.sum_ok     = (chk_exp == chk_byte);
    dec.hit        = 1'b0;
    dec.tvoc_ppb   = {frame[4], frame[5]};
    dec.from_query = 1'b0;
    if (frame[0] == HDR_BYTE) begin
      unique case (frame[1])
        TYPE_UPLOAD: begin
          dec.hit = dec.sum_ok;
        end
        TYPE_QUERY: begin
          dec.hit        = dec.sum_ok;
          dec.tvoc_ppb   = {frame[6], frame[7]};
          dec.from_query = 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/sensor_uart_frame_parser.sv =====
// Top level of the nine-byte gas sensor UART frame parser.
// Depends on sfp_pkg, sfp_in_if, sfp_out_if and sfp_frame_dec.
//
// The block takes one transaction per clock on in_chan: a received UART byte
// (func 0) or a one-millisecond tick (func 1). A 0xFF byte restarts the frame;
// once the ninth byte arrives the checksum (two's complement of the 8-bit sum of
// bytes 1..7) is checked and, for a frame of type 0x17 or 0x86, a 16-bit ppb
// reading is delivered on out_chan, taken from bytes 4-5 or 6-7. Each item
// passes through an input register and the decode logic, and its result is
// held in the output register until out_chan takes it; the sustained rate is
// one item per cycle while the output is not stalled; the single output
// register lets input keep flowing while a result waits, and only an item that
// would produce a second unread result holds the input. Ticks count bus idle
// time, saturating at 17 bits, and drop a partial frame once the count exceeds
// cfg frame_timeout_ticks (reset 100).
module sensor_uart_frame_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  sfp_in_if.sink                     in_chan,
  sfp_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [sfp_pkg::TMO_W-1:0]  cfg_wdata
);
  import sfp_pkg::*;

  // Input register
  logic             in_vld_r;
  logic             in_func_r;
  logic [7:0]       in_byte_r;

  // Parser state
  store_t           frame_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDLE_W-1:0] idle_r, idle_nxt;
  logic [TMO_W-1:0] tmo_r;

  // Output register
  logic             out_vld_r, out_vld_nxt;
  logic [PPB_W-1:0] out_ppb_r;
  logic             out_query_r;

  logic             out_free;
  logic             proc_ok;
  logic             emit;
  logic             wr_en;
  logic [CNT_W-1:0] cnt_eff;
  logic [IDLE_W-1:0] idle_inc;
  dec_t             dec;

  sfp_frame_dec u_dec (
    .frame    (frame_r),
    .chk_byte (in_byte_r),
    .dec      (dec)
  );

  assign out_free = !out_vld_r || out_chan.ready;
  assign proc_ok  = in_vld_r && (!emit || out_free);
  assign in_chan.ready = !in_vld_r || proc_ok;

  // Next parser state for the held item
  always_comb begin
    cnt_nxt  = cnt_r;
    idle_nxt = idle_r;
    emit     = 1'b0;
    wr_en    = 1'b0;
    cnt_eff  = (in_byte_r == HDR_BYTE) ? '0 : cnt_r;
    idle_inc = (idle_r == IDLE_MAX) ? idle_r : idle_r + 1'b1;
    unique case (in_func_r)
      FUNC_TICK: begin
        idle_nxt = idle_inc;
        if (cnt_r != '0 && idle_inc > {1'b0, tmo_r}) begin
          cnt_nxt = '0;
        end
      end
      FUNC_BYTE: begin
        idle_nxt = '0;
        cnt_nxt  = cnt_eff;
        if (cnt_eff < FRAME_CNT) begin
          cnt_nxt = cnt_eff + 1'b1;
          wr_en   = (cnt_eff < CHK_CNT);
        end
        // Ninth byte closes the frame; a failed frame stays full until 0xFF or a timeout
        if (cnt_eff == CHK_CNT && dec.sum_ok) begin
          cnt_nxt = '0;
          emit    = dec.hit;
        end
      end
      default: ;
    endcase
  end

  // Load the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_func_r <= in_chan.func;
      in_byte_r <= in_chan.rx_byte;
    end
  end

  // Advance the parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      idle_r <= '0;
    end else if (proc_ok) begin
      cnt_r  <= cnt_nxt;
      idle_r <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_ok && wr_en) begin
      frame_r[cnt_eff[IDX_W-1:0]] <= in_byte_r;
    end
  end

  // Hold the timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= TMO_RESET;
    end else if (cfg_we) begin
      tmo_r <= cfg_wdata;
    end
  end

  // Output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_free) begin
      out_vld_nxt = proc_ok && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_ok && emit) begin
      out_ppb_r   <= dec.tvoc_ppb;
      out_query_r <= dec.from_query;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.tvoc_ppb   = out_ppb_r;
  assign out_chan.from_query = out_query_r;

endmodule

// ===== rtl/sfp_checker.sv =====
// Port-level assertions for the frame parser, attached by bind.
// Depends on sensor_uart_frame_parser's port list.
module sfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_tvoc_ppb,
  input logic        out_from_query
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_tvoc_ppb) && $stable(out_from_query))
    else $error("result payload changed while stalled");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result follows an accepted byte transaction
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && !in_func, 2))
    else $error("result without a byte transaction");

endmodule

bind sensor_uart_frame_parser sfp_checker u_sfp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_func        (in_chan.func),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_tvoc_ppb   (out_chan.tvoc_ppb),
  .out_from_query (out_chan.from_query)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for sensor_uart_frame_parser: directed and random byte/tick traffic.
// Depends on sfp_pkg, sfp_in_if, sfp_out_if and the parser RTL; keeps its own frame predictor.
`timescale 1ns / 1ps

module testbench;
  import sfp_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 520;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_TMO_TICKS = 120;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic [PPB_W-1:0] tvoc_ppb;
    logic             from_query;
  } reading_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [TMO_W-1:0] cfg_wdata;

  sfp_in_if  in_if ();
  sfp_out_if out_if ();

  sensor_uart_frame_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state
  logic [7:0]        frame_mem [FRAME_LEN];
  int unsigned       byte_cnt;
  logic [IDLE_W-1:0] idle_cnt;
  logic [TMO_W-1:0]  frame_tmo;
  reading_t          pending_readings[$];

  int fail_cnt;
  int items_sent;
  int burst_left;
  int hold_req;
  int stall_cycles;
  bit gaps_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the frame predictor by one accepted transaction
  function automatic void frame_parse_step(logic func, logic [7:0] rx);
    logic [7:0] sum;
    reading_t   r;
    if (func == FUNC_TICK) begin
      if (idle_cnt != IDLE_MAX) idle_cnt = idle_cnt + 1'b1;
      if (byte_cnt != 0 && idle_cnt > IDLE_W'(frame_tmo)) byte_cnt = 0;
    end else begin
      idle_cnt = '0;
      if (rx == HDR_BYTE) byte_cnt = 0;
      if (byte_cnt < FRAME_LEN) begin
        frame_mem[byte_cnt] = rx;
        byte_cnt++;
      end
      if (byte_cnt == FRAME_LEN) begin
        sum = '0;
        for (int i = 1; i <= 7; i++) sum += frame_mem[i];
        sum = ~sum + 8'd1;
        // A bad checksum leaves the count full; later bytes are dropped until a header or timeout
        if (sum == frame_mem[8]) begin
          if (frame_mem[0] == HDR_BYTE && frame_mem[1] == TYPE_UPLOAD) begin
            r.tvoc_ppb   = {frame_mem[4], frame_mem[5]};
            r.from_query = 1'b0;
            pending_readings.push_back(r);
          end else if (frame_mem[0] == HDR_BYTE && frame_mem[1] == TYPE_QUERY) begin
            r.tvoc_ppb   = {frame_mem[6], frame_mem[7]};
            r.from_query = 1'b1;
            pending_readings.push_back(r);
          end
          byte_cnt = 0;
        end
      end
    end
  endfunction

  // Predict on accepted inputs, check accepted readings, watch for a hang
  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) frame_parse_step(in_if.func, in_if.rx_byte);
      if (out_if.valid && out_if.ready) begin
        if (pending_readings.size() == 0) begin
          $error("unexpected reading: tvoc_ppb %h from_query %b",
                 out_if.tvoc_ppb, out_if.from_query);
          fail_cnt++;
        end else begin
          exp_r = pending_readings.pop_front();
          if (out_if.tvoc_ppb !== exp_r.tvoc_ppb) begin
            $error("tvoc_ppb: expected %h, actual %h", exp_r.tvoc_ppb, out_if.tvoc_ppb);
            fail_cnt++;
          end
          if (out_if.from_query !== exp_r.from_query) begin
            $error("from_query: expected %b, actual %b", exp_r.from_query, out_if.from_query);
            fail_cnt++;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result sink: rotate through stall patterns, honor long hold-off requests
  initial begin
    int hold_left;
    int phase_cnt;
    int rx_mode;
    hold_left = 0;
    phase_cnt = 0;
    rx_mode   = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        phase_cnt++;
        if (phase_cnt >= 97) begin
          phase_cnt = 0;
          rx_mode   = $urandom_range(0, 3);
        end
        case (rx_mode)
          0: begin
            out_if.ready <= 1'b1;
          end
          1: begin
            out_if.ready <= ($urandom_range(0, 99) < 60);
          end
          2: begin
            out_if.ready <= (phase_cnt % 4 != 3);
          end
          default: begin
            out_if.ready <= ($urandom_range(0, 99) < 25);
          end
        endcase
      end
    end
  end

  // Drop valid; wait_drain and the input gaps in send_item go through here first
  task automatic idle_input();
    in_if.valid <= 1'b0;
  endtask

  // Offer one transaction and hold it until accepted
  task automatic send_item(logic func, logic [7:0] rx);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        idle_input();
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= func;
    in_if.rx_byte <= rx;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Send frame bytes first..last, sometimes with ticks slipped in between
  task automatic send_frame(frame_t fr, int first, int last, int tick_pct);
    for (int i = first; i <= last; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_ticks($urandom_range(1, 3));
      send_item(FUNC_BYTE, fr[i]);
    end
  endtask

  // Wait until every expected reading has arrived and the pipeline is empty
  task automatic wait_drain();
    idle_input();
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_timeout(logic [TMO_W-1:0] value);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    frame_tmo = value;
  endtask

  // Build a frame with a correct trailing checksum
  function automatic frame_t make_frame(logic [7:0] hdr, logic [7:0] ftype, logic [15:0] mid,
                                        logic [15:0] upload_ppb, logic [15:0] query_ppb);
    frame_t     fr;
    logic [7:0] sum;
    fr[0] = hdr;
    fr[1] = ftype;
    fr[2] = mid[15:8];
    fr[3] = mid[7:0];
    fr[4] = upload_ppb[15:8];
    fr[5] = upload_ppb[7:0];
    fr[6] = query_ppb[15:8];
    fr[7] = query_ppb[7:0];
    sum = '0;
    for (int i = 1; i <= 7; i++) sum += fr[i];
    fr[8] = ~sum + 8'd1;
    return fr;
  endfunction

  // Payload byte: rarely a stray header byte that restarts the frame
  function automatic logic [7:0] body_byte();
    if ($urandom_range(0, 99) < 4) return HDR_BYTE;
    return 8'($urandom_range(0, 254));
  endfunction

  function automatic frame_t random_frame();
    logic [7:0] hdr;
    logic [7:0] ftype;
    int         pick;
    hdr  = ($urandom_range(0, 99) < 92) ? HDR_BYTE : body_byte();
    pick = $urandom_range(0, 99);
    if (pick < 40) ftype = TYPE_UPLOAD;
    else if (pick < 80) ftype = TYPE_QUERY;
    else ftype = 8'($urandom_range(0, 255));
    return make_frame(hdr, ftype, {body_byte(), body_byte()},
                      {body_byte(), body_byte()}, {body_byte(), body_byte()});
  endfunction

  // Both frame types with extreme readings
  task automatic test_frame_types();
    send_frame(make_frame(HDR_BYTE, TYPE_UPLOAD, 16'h0000, 16'h0000, 16'hFEFE), 0, 8, 0);
    send_frame(make_frame(HDR_BYTE, TYPE_UPLOAD, 16'hFEFE, 16'hFEFE, 16'h0000), 0, 8, 0);
    send_frame(make_frame(HDR_BYTE, TYPE_QUERY, 16'h0102, 16'hFEFE, 16'hFEFE), 0, 8, 0);
    send_frame(make_frame(HDR_BYTE, TYPE_QUERY, 16'h5AA5, 16'h1234, 16'h0000), 0, 8, 0);
    wait_drain();
  endtask

  // Bad checksum, then bytes dropped until the next header
  task automatic test_bad_checksum();
    frame_t fr;
    fr = make_frame(HDR_BYTE, TYPE_UPLOAD, 16'h0000, 16'h0321, 16'h0000);
    fr[8] = fr[8] ^ 8'h01;
    send_frame(fr, 0, 8, 0);
    send_item(FUNC_BYTE, 8'h17);
    send_item(FUNC_BYTE, 8'h80);
    send_item(FUNC_BYTE, 8'h00);
    send_frame(make_frame(HDR_BYTE, TYPE_QUERY, 16'h0000, 16'h0000, 16'h0456), 0, 8, 0);
    wait_drain();
  endtask

  // Header mid-frame restarts; good checksum with wrong header or type gives nothing
  task automatic test_header_restart();
    frame_t fr;
    fr = make_frame(HDR_BYTE, TYPE_UPLOAD, 16'h1111, 16'h2222, 16'h3333);
    send_frame(fr, 0, 4, 0);
    send_frame(make_frame(HDR_BYTE, TYPE_UPLOAD, 16'h4444, 16'h0789, 16'h5555), 0, 8, 0);
    send_frame(make_frame(8'h00, TYPE_UPLOAD, 16'h0000, 16'h0abc, 16'h0000), 0, 8, 0);
    send_frame(make_frame(HDR_BYTE, 8'h42, 16'h0000, 16'h0def, 16'h0000), 0, 8, 0);
    send_frame(make_frame(HDR_BYTE, TYPE_QUERY, 16'h0000, 16'h0000, 16'h0777), 0, 8, 0);
    wait_drain();
  endtask

  // Idle timeout at its reset value: exactly at the limit keeps the frame, one past drops it
  task automatic test_idle_timeout();
    frame_t fr;
    gaps_on = 1'b0;
    fr = make_frame(HDR_BYTE, TYPE_UPLOAD, 16'h0000, 16'h0100, 16'h0000);
    send_frame(fr, 0, 3, 0);
    send_ticks(TMO_RESET);
    send_frame(fr, 4, 8, 0);
    send_frame(fr, 0, 3, 0);
    send_ticks(TMO_RESET + 1);
    send_frame(fr, 4, 8, 0);
    gaps_on = 1'b1;
    wait_drain();
  endtask

  // Timeout register at both extremes
  task automatic test_timeout_extremes();
    frame_t fr;
    fr = make_frame(HDR_BYTE, TYPE_QUERY, 16'h0000, 16'h0000, 16'h0AB0);
    set_frame_timeout('0);
    send_frame(fr, 0, 3, 0);
    send_ticks(1);
    send_frame(fr, 4, 8, 0);
    send_frame(fr, 0, 8, 0);
    set_frame_timeout('1);
    gaps_on = 1'b0;
    send_frame(fr, 0, 4, 0);
    send_ticks(MAX_TMO_TICKS);
    send_frame(fr, 5, 8, 0);
    send_frame(fr, 0, 8, 0);
    gaps_on = 1'b1;
    set_frame_timeout(TMO_RESET);
  endtask

  // Hold the sink off while frames keep coming, so the block stalls its input
  task automatic test_backpressure();
    hold_req = LONG_HOLD;
    gaps_on  = 1'b0;
    repeat (6) begin
      send_frame(make_frame(HDR_BYTE, ($urandom_range(0, 1) != 0) ? TYPE_QUERY : TYPE_UPLOAD,
                            16'($urandom_range(0, 16'hFEFE)), 16'($urandom_range(0, 16'hFEFE)),
                            16'($urandom_range(0, 16'hFEFE))), 0, 8, 0);
    end
    gaps_on = 1'b1;
    wait_drain();
  endtask

  // One random stretch of traffic
  task automatic random_sequence();
    frame_t fr;
    int     pick;
    int     tick_cap;
    pick     = $urandom_range(0, 99);
    tick_cap = (frame_tmo < 40) ? int'(frame_tmo) + 2 : 40;
    if (pick < 45) begin
      send_frame(random_frame(), 0, 8, 10);
    end else if (pick < 60) begin
      fr = random_frame();
      fr[8] = fr[8] ^ 8'($urandom_range(1, 255));
      send_frame(fr, 0, 8, 5);
    end else if (pick < 70) begin
      send_frame(random_frame(), 0, $urandom_range(0, 7), 5);
      if ($urandom_range(0, 1) != 0) send_ticks($urandom_range(1, tick_cap));
    end else if (pick < 85) begin
      send_ticks($urandom_range(1, tick_cap));
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 5)) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      wait_drain();
    end
  endtask

  // Random traffic over several timeout settings
  task automatic test_random_traffic();
    int target;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_frame_timeout('0);
        1: set_frame_timeout(TMO_W'($urandom_range(1, 30)));
        2: set_frame_timeout('1);
        3: set_frame_timeout(16'd5);
        default: set_frame_timeout(TMO_RESET);
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      target  = items_sent + RANDOM_ITEMS / 5;
      while (items_sent < target) begin
        if ($urandom_range(0, 19) == 0) gaps_on = ~gaps_on;
        random_sequence();
      end
    end
    gaps_on = 1'b1;
  endtask

  // Main sequence
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.func     = FUNC_BYTE;
    in_if.rx_byte  = '0;
    out_if.ready   = 1'b0;
    for (int i = 0; i < FRAME_LEN; i++) frame_mem[i] = '0;
    byte_cnt     = 0;
    idle_cnt     = '0;
    frame_tmo    = TMO_RESET;
    fail_cnt     = 0;
    items_sent   = 0;
    burst_left   = 0;
    hold_req     = 0;
    stall_cycles = 0;
    gaps_on      = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_frame_types();
    test_bad_checksum();
    test_header_restart();
    test_idle_timeout();
    test_timeout_extremes();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    if (pending_readings.size() != 0) begin
      $error("%0d expected readings never arrived", pending_readings.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sfp_pkg.sv
rtl/sfp_in_if.sv
rtl/sfp_out_if.sv
rtl/sfp_frame_dec.sv
rtl/sensor_uart_frame_parser.sv
rtl/sfp_checker.sv
tb/testbench.sv
